### rtl/smoothing_kernel_weight_top_assert.svh
// Assertion macros used by the checker file of the smoothing kernel weight block.
`ifndef SMOOTHING_KERNEL_WEIGHT_TOP_ASSERT_SVH
`define SMOOTHING_KERNEL_WEIGHT_TOP_ASSERT_SVH

// Checked at each rising clock edge outside reset.
`define SKW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at each rising clock edge, reset included.
`define SKW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/skw_pkg.sv
// Types, constants and elaboration functions of the smoothing kernel weight block.
package skw_pkg;

  typedef enum logic [1:0] {
    KIND_GAUSS = 2'd0,
    KIND_EPAN  = 2'd1,
    KIND_TRI   = 2'd2,
    KIND_TRIW  = 2'd3
  } kind_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_KIND     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BW       = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INV_BW   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_BND_FIX  = 2'd3;

  localparam int unsigned TableBitsDefault = 10;
  localparam int unsigned ExpN = 20;

  localparam logic [31:0] INV_SQRT_PI  = 32'd2423175810;
  localparam logic [32:0] SQ_HALF_PI   = 33'd5382943231;

  localparam logic [31:0] EXP_BITS [ExpN] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
    32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  function automatic logic [63:0] exp_neg(input logic [63:0] v);
    logic [127:0] r;
    r = 128'd1 << 32;
    if (v >= (64'd16 << 16)) begin
      r = '0;
    end else begin
      for (int b = 0; b < ExpN; b++) begin
        if (v[b]) begin
          r = (r * 128'(EXP_BITS[b]) + (128'd1 << 31)) >> 32;
        end
      end
    end
    return r[63:0];
  endfunction

endpackage

### rtl/smoothing_kernel_weight_top.sv
// Top level of the smoothing kernel weight pipeline.
// The block takes one request per cycle while its skid stage is empty. The exponential
// chain spends one multiplier stage on each bit of the squared distance, and the boundary
// divider resolves one quotient bit per stage. An output register with a one-entry skid
// stage lets the pipeline keep taking requests while a result waits. The user must write
// configuration only while the pipeline is empty; the block itself does not enforce this.
module smoothing_kernel_weight_top
  import skw_pkg::*;
#(
  parameter int unsigned TABLE_BITS = TableBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [31:0]         s_axis_tdata_i,  // observed_time [15:0], grid_time [31:16]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [31:0]         m_axis_tdata_o,  // weight [31:0]
  output logic                m_axis_tuser_o,  // saturated [0]
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned Sh     = 18 - TABLE_BITS;
  localparam int unsigned RomN   = 1 << TABLE_BITS;
  localparam int unsigned ExpOff = 6;
  localparam int unsigned G1     = ExpOff + ExpN;
  localparam int unsigned DivOff = G1 + 3;
  localparam int unsigned NStg   = DivOff + 32;

  typedef logic [65:0] rom_t [RomN];

  function automatic rom_t build_rom();
    logic [127:0] s;
    logic [127:0] prev;
    logic [127:0] f;
    logic [127:0] integ;
    logic [127:0] e;
    logic [63:0]  arg;
    logic [32:0]  ent [RomN+1];
    rom_t         rom;
    s = '0;
    prev = 128'(exp_neg(64'd0));
    ent[0] = '0;
    for (int i = 1; i <= RomN; i++) begin
      arg = ((64'(i) * 64'(i)) << 20) + (64'd1 << (2 * TABLE_BITS - 1));
      f = 128'(exp_neg(arg >> (2 * TABLE_BITS)));
      s = s + prev + f;
      prev = f;
      integ = (s + (128'd1 << (TABLE_BITS - 2))) >> (TABLE_BITS - 1);
      e = (integ * 128'(INV_SQRT_PI) + (128'd1 << 30)) >> 31;
      ent[i] = (e > (128'd1 << 32)) ? 33'h1_0000_0000 : e[32:0];
    end
    for (int i = 0; i < RomN; i++) begin
      rom[i] = {ent[i+1], ent[i]};
    end
    return rom;
  endfunction

  localparam rom_t ERF_ROM = build_rom();

  kind_e        kind_q;
  logic [19:0]  bw_q;
  logic [31:0]  inv_q;
  logic         bfix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_GAUSS;
      bw_q   <= 20'd65536;
      inv_q  <= 32'd65536;
      bfix_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KIND:    kind_q <= kind_e'(cfg_data_i[1:0]);
        REG_BW:      bw_q   <= cfg_data_i[19:0];
        REG_INV_BW:  inv_q  <= cfg_data_i;
        REG_BND_FIX: bfix_q <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  logic            en;
  logic [NStg-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid_i};
    end
  end

  // Stage 1: distance and support test.
  logic [15:0] t1, t0, d_d, d_q, t0_q;
  logic        oos_d, oos_q;

  always_comb begin
    t1 = s_axis_tdata_i[15:0];
    t0 = s_axis_tdata_i[31:16];
    d_d = (t1 > t0) ? (t1 - t0) : (t0 - t1);
    oos_d = (kind_q != KIND_GAUSS) && ({4'd0, d_d} > bw_q);
  end

  // Stage 2: scaled distance and boundary arguments.
  logic [48:0] pu, pa, pb;
  logic [16:0] xa;
  logic [32:0] u_d, u_q;
  logic [17:0] ya_d, ya_q, yb_d, yb_q;
  logic        ybig_a_d, ybig_a_q, ybig_b_d, ybig_b_q;
  logic        oos2_q;

  always_comb begin
    pu = 49'(d_q) * 49'(inv_q) + 49'(1 << 15);
    u_d = pu[48:16];
    xa = 17'd65536 - 17'(t0_q);
    pa = 49'(xa) * 49'(inv_q) + 49'(1 << 15);
    pb = 49'(t0_q) * 49'(inv_q) + 49'(1 << 15);
    ya_d = pa[33:16];
    yb_d = pb[33:16];
    ybig_a_d = |pa[48:34];
    ybig_b_d = |pb[48:34];
  end

  // Stage 3: squares and scaled boundary arguments.
  logic [35:0] uu;
  logic [36:0] uur;
  logic [31:0] uc2;
  logic [19:0] v_d, v_q;
  logic        gz_d, gz_q, cz_d, cz_q;
  logic [32:0] om_d, om_q;
  logic [24:0] ktri_d, ktri_q;
  logic [51:0] pza, pzb;
  logic [17:0] za_d, za_q, zb_d, zb_q;
  logic        one_a_d, one_a_q, one_b_d, one_b_q;
  logic        oos3_q;

  always_comb begin
    gz_d = |u_q[32:18];
    uu = 36'(u_q[17:0]) * 36'(u_q[17:0]);
    uur = 37'(uu) + 37'(1 << 15);
    v_d = uur[35:16];
    cz_d = |u_q[32:16];
    uc2 = 32'(u_q[15:0]) * 32'(u_q[15:0]);
    om_d = 33'h1_0000_0000 - 33'(uc2);
    ktri_d = 25'((17'd65536 - 17'(u_q[15:0])) << 8);
    pza = 52'(ya_q) * 52'(SQ_HALF_PI) + 52'(64'd1 << 31);
    pzb = 52'(yb_q) * 52'(SQ_HALF_PI) + 52'(64'd1 << 31);
    za_d = pza[49:32];
    zb_d = pzb[49:32];
    one_a_d = ybig_a_q || (|pza[51:50]);
    one_b_d = ybig_b_q || (|pzb[51:50]);
  end

  // Stage 4: compact kernel terms and table read.
  logic [33:0] omr;
  logic [49:0] ww;
  logic [34:0] kep_p;
  logic [24:0] w_d, w_q, w2_d, w2_q, kep_d, kep_q, ktri4_q;
  logic [65:0] rom_a_q, rom_b_q;
  logic [Sh-1:0] fr_a_q, fr_b_q;
  logic        one_a4_q, one_b4_q, cz4_q, gz4_q, oos4_q;
  logic [19:0] v4_q;

  always_comb begin
    omr = 34'(om_q) + 34'd128;
    w_d = omr[32:8];
    ww = 50'(w_d) * 50'(w_d) + 50'(1 << 23);
    w2_d = ww[48:24];
    kep_p = 35'(om_q) * 35'd3 + 35'd512;
    kep_d = kep_p[34:10];
  end

  // Stage 5: cube term and interpolation.
  logic [49:0] w3p;
  logic [24:0] w3_d, w3_q, kep5_q, ktri5_q;
  logic [32:0] ea_d, ea_q, eb_d, eb_q;
  logic [32:0] lo_a, hi_a, lo_b, hi_b;
  logic [33+Sh:0] ip_a, ip_b;
  logic        cz5_q, gz5_q, oos5_q;
  logic [19:0] v5_q;

  always_comb begin
    w3p = 50'(w2_q) * 50'(w_q) + 50'(1 << 23);
    w3_d = w3p[48:24];
    lo_a = rom_a_q[32:0];
    hi_a = rom_a_q[65:33];
    lo_b = rom_b_q[32:0];
    hi_b = rom_b_q[65:33];
    ip_a = (34'(hi_a - lo_a) * (34 + Sh)'(fr_a_q) + (34 + Sh)'(1 << (Sh - 1))) >> Sh;
    ip_b = (34'(hi_b - lo_b) * (34 + Sh)'(fr_b_q) + (34 + Sh)'(1 << (Sh - 1))) >> Sh;
    ea_d = one_a4_q ? 33'h1_0000_0000 : 33'((34 + Sh)'(lo_a) + ip_a);
    eb_d = one_b4_q ? 33'h1_0000_0000 : 33'((34 + Sh)'(lo_b) + ip_b);
  end

  // Stage 6: compact kernel select and boundary denominator.
  logic [30:0] ktw_p;
  logic [24:0] kc_d;
  logic [33:0] den_s;
  logic [32:0] den_d;

  always_comb begin
    ktw_p = 31'(w3_q) * 31'd35 + 31'd16;
    case (kind_q)
      KIND_EPAN: kc_d = kep5_q;
      KIND_TRI:  kc_d = ktri5_q;
      KIND_TRIW: kc_d = ktw_p[29:5];
      default:   kc_d = '0;
    endcase
    if (cz5_q) begin
      kc_d = '0;
    end
    den_s = 34'(ea_q) + 34'(eb_q) + 34'd1;
    den_d = den_s[33:1];
    if (den_d == '0) begin
      den_d = 33'd1;
    end
  end

  // Exponential chain, entry 0 is the output of stage 6.
  logic [32:0] xr_q [ExpN+1];
  logic [19:0] xv_q [ExpN+1];
  logic [24:0] xk_q [ExpN+1];
  logic [32:0] xd_q [ExpN+1];
  logic        xg_q [ExpN+1];
  logic        xo_q [ExpN+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q      <= d_d;
      t0_q     <= t0;
      oos_q    <= oos_d;
      u_q      <= u_d;
      ya_q     <= ya_d;
      yb_q     <= yb_d;
      ybig_a_q <= ybig_a_d;
      ybig_b_q <= ybig_b_d;
      oos2_q   <= oos_q;
      v_q      <= v_d;
      gz_q     <= gz_d;
      cz_q     <= cz_d;
      om_q     <= om_d;
      ktri_q   <= ktri_d;
      za_q     <= za_d;
      zb_q     <= zb_d;
      one_a_q  <= one_a_d;
      one_b_q  <= one_b_d;
      oos3_q   <= oos2_q;
      w_q      <= w_d;
      w2_q     <= w2_d;
      kep_q    <= kep_d;
      ktri4_q  <= ktri_q;
      rom_a_q  <= ERF_ROM[za_q[17:Sh]];
      rom_b_q  <= ERF_ROM[zb_q[17:Sh]];
      fr_a_q   <= za_q[Sh-1:0];
      fr_b_q   <= zb_q[Sh-1:0];
      one_a4_q <= one_a_q;
      one_b4_q <= one_b_q;
      cz4_q    <= cz_q;
      gz4_q    <= gz_q;
      oos4_q   <= oos3_q;
      v4_q     <= v_q;
      w3_q     <= w3_d;
      kep5_q   <= kep_q;
      ktri5_q  <= ktri4_q;
      ea_q     <= ea_d;
      eb_q     <= eb_d;
      cz5_q    <= cz4_q;
      gz5_q    <= gz4_q;
      oos5_q   <= oos4_q;
      v5_q     <= v4_q;
      xr_q[0]  <= 33'h1_0000_0000;
      xv_q[0]  <= v5_q;
      xk_q[0]  <= kc_d;
      xd_q[0]  <= den_d;
      xg_q[0]  <= gz5_q;
      xo_q[0]  <= oos5_q;
    end
  end

  for (genvar j = 0; j < ExpN; j++) begin : g_exp
    logic [65:0] ep;
    logic [32:0] er_d;
    always_comb begin
      ep = 66'(xr_q[j]) * 66'(EXP_BITS[j]) + 66'(64'd1 << 31);
      er_d = xv_q[j][j] ? ep[64:32] : xr_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        xr_q[j+1] <= er_d;
        xv_q[j+1] <= xv_q[j];
        xk_q[j+1] <= xk_q[j];
        xd_q[j+1] <= xd_q[j];
        xg_q[j+1] <= xg_q[j];
        xo_q[j+1] <= xo_q[j];
      end
    end
  end

  // Gaussian scaling, weight and boundary decision.
  logic [65:0] kgp;
  logic [24:0] k_d, k_q;
  logic [57:0] wqp;
  logic [32:0] wq_d, wq_q;
  logic [32:0] dn1_q, dn2_q;
  logic        o1_q;
  logic        bnd, sat_d, mode_d;
  logic [31:0] res_d;

  always_comb begin
    kgp = 66'(xr_q[ExpN]) * 66'(INV_SQRT_PI) + 66'(64'd1 << 39);
    if (kind_q == KIND_GAUSS) begin
      k_d = xg_q[ExpN] ? 25'd0 : kgp[64:40];
    end else begin
      k_d = xk_q[ExpN];
    end
    wqp = 58'(k_q) * 58'(inv_q) + 58'(1 << 23);
    wq_d = o1_q ? 33'd0 : wqp[56:24];
    bnd = (kind_q == KIND_GAUSS) && bfix_q;
    if (bnd) begin
      sat_d = (wq_q >= dn2_q);
    end else begin
      sat_d = wq_q[32];
    end
    mode_d = bnd && !sat_d;
    res_d = sat_d ? 32'hFFFF_FFFF : wq_q[31:0];
  end

  // Divider chain, entry 0 is the output of the decision stage.
  logic [32:0] dr_q   [33];
  logic [31:0] dh_q   [33];
  logic [31:0] dq_q   [33];
  logic [32:0] dd_q   [33];
  logic        dm_q   [33];
  logic        ds_q   [33];
  logic [31:0] dres_q [33];

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_q       <= k_d;
      dn1_q     <= xd_q[ExpN];
      o1_q      <= xo_q[ExpN];
      wq_q      <= wq_d;
      dn2_q     <= dn1_q;
      dr_q[0]   <= wq_q;
      dh_q[0]   <= dn2_q[32:1];
      dq_q[0]   <= '0;
      dd_q[0]   <= dn2_q;
      dm_q[0]   <= mode_d;
      ds_q[0]   <= sat_d;
      dres_q[0] <= res_d;
    end
  end

  for (genvar i = 0; i < 32; i++) begin : g_div
    logic [33:0] rem2;
    logic        ge;
    logic [33:0] dif;
    always_comb begin
      rem2 = {dr_q[i], dh_q[i][31-i]};
      ge = rem2 >= 34'(dd_q[i]);
      dif = rem2 - 34'(dd_q[i]);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dr_q[i+1]   <= ge ? dif[32:0] : rem2[32:0];
        dh_q[i+1]   <= dh_q[i];
        dq_q[i+1]   <= {dq_q[i][30:0], ge};
        dd_q[i+1]   <= dd_q[i];
        dm_q[i+1]   <= dm_q[i];
        ds_q[i+1]   <= ds_q[i];
        dres_q[i+1] <= dres_q[i];
      end
    end
  end

  // Output register and skid stage.
  logic        fin_vld;
  logic [31:0] fin_data;
  logic        fin_sat;
  logic        out_vld_q, sk_vld_q;
  logic [31:0] out_data_q, sk_data_q;
  logic        out_sat_q, sk_sat_q;
  logic        ld_out, ld_sk, from_sk;

  always_comb begin
    en = !sk_vld_q;
    fin_vld = vld_q[NStg-1];
    fin_data = dm_q[32] ? dq_q[32] : dres_q[32];
    fin_sat = ds_q[32];
    ld_sk = en && fin_vld && out_vld_q && !m_axis_tready_i;
    ld_out = en && fin_vld && !ld_sk;
    from_sk = !en && m_axis_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else begin
      if (ld_sk) begin
        sk_vld_q <= 1'b1;
      end else if (from_sk) begin
        sk_vld_q <= 1'b0;
      end
      if (ld_out || from_sk) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_sk) begin
      sk_data_q <= fin_data;
      sk_sat_q  <= fin_sat;
    end
    if (ld_out) begin
      out_data_q <= fin_data;
      out_sat_q  <= fin_sat;
    end else if (from_sk) begin
      out_data_q <= sk_data_q;
      out_sat_q  <= sk_sat_q;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

endmodule

### rtl/skw_chk.sv
// Port checker of the smoothing kernel weight block and its bind to the top level.
`include "smoothing_kernel_weight_top_assert.svh"

module skw_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_i,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [31:0] m_tdata_i,
  input logic        m_tuser_i
);

  `SKW_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !m_tvalid_i, "result valid during reset")
  `SKW_ASSERT(a_sat_ones, m_tvalid_i && m_tuser_i |-> m_tdata_i == 32'hFFFF_FFFF, "bad clip")
  `SKW_ASSERT(a_stall_src, !s_tready_i |-> m_tvalid_i, "input stalled without pending result")
  `SKW_ASSERT(a_vld_hold, m_tvalid_i && !m_tready_i |=> m_tvalid_i, "result dropped")
  `SKW_ASSERT(a_data_hold, m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i), "result changed")

endmodule

bind smoothing_kernel_weight_top skw_chk u_skw_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

### bench/tb.sv
// Self-checking testbench for the smoothing kernel weight pipeline, with random stimulus.
`timescale 1ns / 1ps
module tb;
  import skw_pkg::*;

  localparam int unsigned TB_BITS = 10;
  localparam int unsigned ROM_N = 1 << TB_BITS;
  localparam int unsigned WATCH_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [127:0] ONE_Q32 = 128'd1 << 32;
  localparam logic [127:0] RSQRT_PI_Q32 = 128'd2423175810;
  localparam logic [127:0] SQRT_HALF_PI_Q32 = 128'd5382943231;
  localparam logic [31:0] DECAY_Q32 [20] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
    32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  typedef struct packed {
    logic [15:0] grid;
    logic [15:0] obs;
  } time_pair_t;

  typedef struct packed {
    logic [31:0] weight;
    logic        sat;
  } weight_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [31:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [31:0] m_data;
  logic m_user;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = REG_KIND;
  logic [31:0] cfg_dat = '0;

  kind_e       kind_q = KIND_GAUSS;
  logic [19:0] bw_q = 20'd65536;
  logic [31:0] inv_bw_q = 32'd65536;
  logic        bnd_q = 1'b0;

  logic [127:0] erf_rom [ROM_N+1];
  time_pair_t   pending_pairs [$];
  weight_res_t  expected_weights [$];
  int unsigned  errors = 0;
  int unsigned  tx_gap = 0;
  int unsigned  rx_gap = 0;
  int unsigned  hold_cnt = 0;
  int unsigned  idle_cycles = 0;
  bit           req_taken = 0;
  bit           quiet = 0;
  bit           long_hold_req = 0;

  smoothing_kernel_weight_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_data_i      (cfg_dat)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [127:0] neg_exp_q32(logic [127:0] v);
    logic [127:0] r;
    r = ONE_Q32;
    if (v >= (128'd16 << 16)) return '0;
    for (int b = 0; b < 20; b++) begin
      if (v[b]) r = (r * 128'(DECAY_Q32[b]) + (128'd1 << 31)) >> 32;
    end
    return r;
  endfunction

  function automatic void fill_erf_rom();
    logic [127:0] acc, prev, arg, f, integ, e;
    acc = '0;
    prev = neg_exp_q32('0);
    erf_rom[0] = '0;
    for (int unsigned i = 1; i <= ROM_N; i++) begin
      arg = ((128'(i) * 128'(i)) << 20) + (128'd1 << (2 * TB_BITS - 1));
      f = neg_exp_q32(arg >> (2 * TB_BITS));
      acc = acc + prev + f;
      prev = f;
      integ = (acc + (128'd1 << (TB_BITS - 2))) >> (TB_BITS - 1);
      e = (integ * RSQRT_PI_Q32 + (128'd1 << 30)) >> 31;
      erf_rom[i] = (e > ONE_Q32) ? ONE_Q32 : e;
    end
  endfunction

  function automatic logic [127:0] erf_scaled(logic [127:0] x);
    logic [127:0] y, z, lo, hi;
    int unsigned idx, frac;
    y = (x * 128'(inv_bw_q) + (128'd1 << 15)) >> 16;
    if (y >= (128'd4 << 16)) return ONE_Q32;
    z = (y * SQRT_HALF_PI_Q32 + (128'd1 << 31)) >> 32;
    if (z >= (128'd4 << 16)) return ONE_Q32;
    idx = int'(z >> (18 - TB_BITS));
    frac = int'(z & ((128'd1 << (18 - TB_BITS)) - 1));
    lo = erf_rom[idx];
    hi = erf_rom[idx+1];
    return lo + (((hi - lo) * 128'(frac) + (128'd1 << (17 - TB_BITS))) >> (18 - TB_BITS));
  endfunction

  function automatic logic [127:0] kernel_q24(logic [127:0] u);
    logic [127:0] om, w, w2, w3;
    if (kind_q == KIND_GAUSS) begin
      if (u >= (128'd4 << 16)) return '0;
      w = neg_exp_q32((u * u + (128'd1 << 15)) >> 16);
      return (w * RSQRT_PI_Q32 + (128'd1 << 39)) >> 40;
    end
    if (u >= (128'd1 << 16)) return '0;
    if (kind_q == KIND_TRI) return ((128'd1 << 16) - u) << 8;
    om = ONE_Q32 - u * u;
    if (kind_q == KIND_EPAN) return (128'd3 * om + 128'd512) >> 10;
    w = (om + 128'd128) >> 8;
    w2 = (w * w + (128'd1 << 23)) >> 24;
    w3 = (w2 * w + (128'd1 << 23)) >> 24;
    return (128'd35 * w3 + 128'd16) >> 5;
  endfunction

  function automatic weight_res_t smoothing_weight(time_pair_t p);
    logic [127:0] dlt, u, wq, den;
    weight_res_t r;
    r = '0;
    dlt = (p.obs > p.grid) ? 128'(p.obs - p.grid) : 128'(p.grid - p.obs);
    if (kind_q != KIND_GAUSS && dlt > 128'(bw_q)) return r;
    u = (dlt * 128'(inv_bw_q) + (128'd1 << 15)) >> 16;
    wq = (kernel_q24(u) * 128'(inv_bw_q) + (128'd1 << 23)) >> 24;
    if (kind_q == KIND_GAUSS && bnd_q) begin
      den = (erf_scaled(128'd65536 - 128'(p.grid)) + erf_scaled(128'(p.grid)) + 1) >> 1;
      if (den == 0) den = 1;
      if (wq >= den) begin
        r.weight = '1;
        r.sat = 1'b1;
      end else begin
        r.weight = 32'(((wq << 32) + (den >> 1)) / den);
      end
    end else if (wq > 128'hFFFF_FFFF) begin
      r.weight = '1;
      r.sat = 1'b1;
    end else begin
      r.weight = wq[31:0];
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  always @(negedge clk_i) begin : driver
    logic nv;
    time_pair_t p;
    nv = s_valid;
    if (rst_ni) begin
      if (!s_valid || req_taken) begin
        nv = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_pairs.size() > 0) begin
          p = pending_pairs.pop_front();
          s_data <= p;
          nv = 1'b1;
          tx_gap = pick_gap();
        end
      end
      req_taken = 0;
    end
    s_valid <= nv;
  end

  always @(negedge clk_i) begin : receiver
    logic nr;
    nr = 1'b0;
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        hold_cnt = 400;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else begin
        nr = 1'b1;
        rx_gap = pick_gap();
      end
    end
    m_ready <= nr;
  end

  always @(posedge clk_i) begin : monitor
    weight_res_t got, want;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        expected_weights.push_back(smoothing_weight(s_data));
        req_taken = 1;
      end
      if (m_valid && m_ready) begin
        got.weight = m_data;
        got.sat = m_user;
        if (expected_weights.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_data));
        end else begin
          want = expected_weights.pop_front();
          if (got.weight !== want.weight)
            report_mismatch($sformatf("weight %h, expected %h", got.weight, want.weight));
          if (got.sat !== want.sat)
            report_mismatch($sformatf("saturated %b, expected %b", got.sat, want.sat));
        end
      end
      if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || s_valid || expected_weights.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_cfg(kind_e k, logic [19:0] bw, logic [31:0] inv, logic bnd);
    logic [31:0] vals [4];
    logic [CfgIdxW-1:0] idxs [4];
    vals = '{32'(k), 32'(bw), inv, 32'(bnd)};
    idxs = '{REG_KIND, REG_BW, REG_INV_BW, REG_BND_FIX};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= idxs[i];
      cfg_dat <= vals[i];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    kind_q = k;
    bw_q = bw;
    inv_bw_q = inv;
    bnd_q = bnd;
  endtask

  task automatic push_pair(logic [15:0] obs, logic [15:0] grid);
    time_pair_t p;
    p.obs = obs;
    p.grid = grid;
    pending_pairs.push_back(p);
  endtask

  task automatic push_random_pairs(int unsigned n);
    int unsigned r, lim, t0, offs;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        lim = bw_q + bw_q / 4;
        if (lim > 65535) lim = 65535;
        t0 = $urandom_range(0, 65535);
        offs = $urandom_range(0, lim);
        if ($urandom_range(0, 1)) push_pair(16'((t0 + offs > 65535) ? 65535 : t0 + offs), 16'(t0));
        else push_pair(16'((t0 < offs) ? 0 : t0 - offs), 16'(t0));
      end else if (r == 6) begin
        t0 = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(65235, 65535);
        push_pair(16'($urandom_range(0, 65535)), 16'(t0));
      end else begin
        push_pair(16'($urandom), 16'($urandom));
      end
    end
  endtask

  function automatic logic [31:0] recip_of(logic [19:0] bw);
    logic [63:0] q;
    if (bw == 0) return '1;
    q = ((64'd1 << 32) + 64'(bw / 2)) / 64'(bw);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  initial begin : stimulus
    kind_e k;
    logic [19:0] bw;
    logic [31:0] inv;
    fill_erf_rom();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_pair(16'd0, 16'd0);
    push_pair(16'hFFFF, 16'd0);
    push_pair(16'd0, 16'hFFFF);
    push_pair(16'hFFFF, 16'hFFFF);
    push_pair(16'd1000, 16'd1200);
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      k = kind_e'(i);
      apply_cfg(k, 20'd16384, 32'd262144, 1'b1);
      push_pair(16'd0, 16'd0);
      push_pair(16'd16384, 16'd0);
      push_pair(16'd16385, 16'd0);
      push_pair(16'd16383, 16'd1);
      push_pair(16'h8000, 16'hFFFF);
      wait_drained();
    end

    for (int ph = 0; ph < 17; ph++) begin
      k = kind_e'($urandom_range(0, 3));
      bw = 20'($urandom_range(1, 65536));
      inv = recip_of(bw);
      case (ph)
        0: begin bw = 20'hFFFFF; inv = 32'd1; end
        1: begin bw = 20'd1; inv = 32'hFFFF_FFFF; end
        2: begin bw = 20'd0; inv = 32'd0; end
        3: begin bw = 20'd2000; inv = recip_of(bw); k = KIND_GAUSS; end
        default: begin
          if ($urandom_range(0, 4) == 0) inv = $urandom;
          if ($urandom_range(0, 5) == 0) bw = 20'($urandom);
        end
      endcase
      apply_cfg(k, bw, inv, ph == 3 ? 1'b1 : 1'($urandom_range(0, 1)));
      quiet = (ph % 5 == 4);
      if (ph == 6) begin
        quiet = 1;
        long_hold_req = 1;
        push_random_pairs(150);
      end else begin
        push_random_pairs(45);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
